// ----- design/polygon_area_centroid_macros.svh -----
// Assertion shorthands shared by the polygon centroid design.
// Both forms sample on i_clk and are disabled while i_rst_n is low.
`ifndef POLYGON_AREA_CENTROID_MACROS_SVH
`define POLYGON_AREA_CENTROID_MACROS_SVH

// Same-cycle implication.
`define PAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pac_pkg.sv -----
// ----------------------------------------------------------------------------
// pac_pkg
// Shared widths, payload structs, controller states and command/status
// bundles of the polygon area and centroid accumulator.
// ----------------------------------------------------------------------------
package pac_pkg;

    localparam int IN_COORD_W        = 16;
    localparam int OUT_COORD_W       = 32;
    localparam int SUM_W             = 64;
    localparam int AREA_W            = 48;
    localparam int DEN_W             = AREA_W + 2;
    localparam int QUO_W             = 41;
    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [QUO_W-1:0]       QUO_LIMIT = {1'b1, {(QUO_W-1){1'b0}}};
    localparam logic [OUT_COORD_W-1:0] OUT_MAX   = {1'b0, {(OUT_COORD_W-1){1'b1}}};
    localparam logic [OUT_COORD_W-1:0] OUT_MIN   = {1'b1, {(OUT_COORD_W-1){1'b0}}};
    localparam logic [SUM_W-1:0]       SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0]       SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [AREA_W-1:0]      AREA_MAX  = {1'b0, {(AREA_W-1){1'b1}}};
    localparam logic [AREA_W-1:0]      AREA_MIN  = {1'b1, {(AREA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [IN_COORD_W-1:0] x_coord;
        logic signed [IN_COORD_W-1:0] y_coord;
        logic                         ring_start;
        logic                         set_base;
        logic                         is_hole;
        logic                         ring_ccw;
        logic                         clear_sums;
        logic                         want_result;
    } t_pac_vertex;

    typedef struct packed {
        logic signed [OUT_COORD_W-1:0] centroid_x;
        logic signed [OUT_COORD_W-1:0] centroid_y;
        logic                          centroid_defined;
        logic                          sum_overflow;
    } t_pac_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_WEIGHT,
        ST_ACCUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_LOAD
    } t_pac_state;

    typedef struct packed {
        logic capture;
        logic area;
        logic weight;
        logic accum;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_pac_cmd;

    typedef struct packed {
        logic want_result;
        logic area_zero;
        logic div_last;
        logic out_free;
    } t_pac_sts;

endpackage

// ----- design/pac_chan_if.sv -----
// ----------------------------------------------------------------------------
// pac_chan_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface pac_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/pac_div_lane.sv -----
// ----------------------------------------------------------------------------
// pac_div_lane
// Restoring divider lane: |num| * 2^F / den, one quotient bit per step,
// quotient clamped at 2^40, then signed and saturated to 32 bits.
// ----------------------------------------------------------------------------
module pac_div_lane (
    input  logic                                    i_clk,
    input  logic                                    i_init,
    input  logic                                    i_step,
    input  logic signed [pac_pkg::SUM_W-1:0]        i_num,
    input  logic                                    i_area_neg,
    input  logic        [pac_pkg::DEN_W-1:0]        i_den,
    output logic signed [pac_pkg::OUT_COORD_W-1:0]  o_quot
);
    import pac_pkg::*;

    localparam logic [QUO_W-1:0] Q_NEG_LIM = QUO_W'(64'h8000_0000);
    localparam logic [QUO_W-1:0] Q_POS_LIM = QUO_W'(64'h7fff_ffff);

    logic [SUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic             r_big;
    logic             r_neg;

    logic [DEN_W-1:0] n_rem;
    logic [QUO_W-1:0] n_quo;
    logic             n_big;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;
    logic [QUO_W:0]   w_qs;

    // Shift in the next numerator bit, trial subtract, clamp the quotient
    always_comb begin
        w_shift = {r_rem, r_num[SUM_W-1]};
        w_diff  = w_shift - {1'b0, i_den};
        w_ge    = (w_shift >= {1'b0, i_den});
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        w_qs    = {r_quo, w_ge};
        if (w_qs > {1'b0, QUO_LIMIT}) begin
            n_quo = QUO_LIMIT;
            n_big = 1'b1;
        end else begin
            n_quo = w_qs[QUO_W-1:0];
            n_big = r_big;
        end
    end

    // Load magnitude and sign, then advance one bit per step
    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_num <= i_num[SUM_W-1] ? (SUM_W'(0) - i_num) : i_num;
            r_neg <= i_num[SUM_W-1] ^ i_area_neg;
            r_rem <= '0;
            r_quo <= '0;
            r_big <= 1'b0;
        end else if (i_step) begin
            r_num <= {r_num[SUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_big <= n_big;
        end
    end

    // Apply sign and saturate to the output range
    always_comb begin
        if (r_neg) begin
            if (r_big || (r_quo > Q_NEG_LIM)) begin
                o_quot = OUT_MIN;
            end else begin
                o_quot = OUT_COORD_W'(0) - r_quo[OUT_COORD_W-1:0];
            end
        end else begin
            if (r_big || (r_quo > Q_POS_LIM)) begin
                o_quot = OUT_MAX;
            end else begin
                o_quot = r_quo[OUT_COORD_W-1:0];
            end
        end
    end

endmodule

// ----- design/pac_dp.sv -----
// ----------------------------------------------------------------------------
// pac_dp
// Datapath: base and previous vertex, fan-triangle twice-area, weighted
// products, saturating sums, two divider lanes and the output register.
// ----------------------------------------------------------------------------
module pac_dp #(
    parameter int COORD_BITS    = pac_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = pac_pkg::FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pac_pkg::t_pac_cmd    i_cmd,
    input  pac_pkg::t_pac_vertex i_vertex,
    output pac_pkg::t_pac_sts    o_sts,
    output pac_pkg::t_pac_result o_res,
    output logic                 o_res_valid,
    input  logic                 i_res_ready
);
    import pac_pkg::*;

    localparam int DIFF_W    = COORD_BITS + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int A2_W      = PROD_W + 1;
    localparam int C3_W      = COORD_BITS + 2;
    localparam int WP_W      = A2_W + C3_W;
    localparam int EXT_W     = (WP_W > SUM_W) ? WP_W : SUM_W + 1;
    localparam int DIV_STEPS = SUM_W + FRACTION_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Clamp a full product to the sum width; top bit flags saturation
    function automatic logic [SUM_W:0] f_sat_prod(input logic signed [EXT_W-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[EXT_W-1:SUM_W-1];
        hi_zeros = ~|v[EXT_W-1:SUM_W-1];
        if (hi_ones || hi_zeros) begin
            f_sat_prod = {1'b0, v[SUM_W-1:0]};
        end else begin
            f_sat_prod = {1'b1, (v[EXT_W-1] ? SUM_MIN : SUM_MAX)};
        end
    endfunction

    // Saturating add at the sum width; top bit flags saturation
    function automatic logic [SUM_W:0] f_sat_sum(input logic signed [SUM_W-1:0] a,
                                                 input logic signed [SUM_W-1:0] b);
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (s[SUM_W] != s[SUM_W-1]) begin
            f_sat_sum = {1'b1, (s[SUM_W] ? SUM_MIN : SUM_MAX)};
        end else begin
            f_sat_sum = {1'b0, s[SUM_W-1:0]};
        end
    endfunction

    // Vertex coordinates at the configured grid width
    logic signed [COORD_BITS-1:0] w_cx;
    logic signed [COORD_BITS-1:0] w_cy;

    generate
        if (COORD_BITS <= IN_COORD_W) begin : g_coord_trunc
            assign w_cx = i_vertex.x_coord[COORD_BITS-1:0];
            assign w_cy = i_vertex.y_coord[COORD_BITS-1:0];
        end else begin : g_coord_ext
            assign w_cx = {{(COORD_BITS-IN_COORD_W){i_vertex.x_coord[IN_COORD_W-1]}},
                           i_vertex.x_coord};
            assign w_cy = {{(COORD_BITS-IN_COORD_W){i_vertex.y_coord[IN_COORD_W-1]}},
                           i_vertex.y_coord};
        end
    endgenerate

    // Architectural state
    logic signed [COORD_BITS-1:0] r_base_x, r_base_y, r_prev_x, r_prev_y;
    logic signed [SUM_W-1:0]      r_wx, r_wy;
    logic signed [AREA_W-1:0]     r_area;
    logic                         r_ovf;

    // Per-vertex working registers
    logic signed [DIFF_W-1:0]     r_dpx, r_dpy, r_dcx, r_dcy;
    logic signed [C3_W-1:0]       r_c3x, r_c3y;
    logic                         r_flip, r_tri, r_want;
    logic signed [A2_W-1:0]       r_a2;
    logic signed [SUM_W-1:0]      r_wpx, r_wpy;
    logic                         r_wpx_ovf, r_wpy_ovf;
    logic [DEN_W-1:0]             r_den;
    logic [CNT_W-1:0]             r_cnt;
    t_pac_result                  r_res;
    logic                         r_res_valid;

    logic signed [COORD_BITS-1:0] w_base_x, w_base_y;
    logic signed [PROD_W-1:0]     w_p1, w_p2;
    logic signed [A2_W-1:0]       w_a2;
    logic signed [WP_W-1:0]       w_wpx, w_wpy;
    logic [SUM_W:0]               w_satpx, w_satpy, w_sumx, w_sumy;
    logic signed [AREA_W:0]       w_area_sum;
    logic                         w_area_ovf;
    logic [AREA_W-1:0]            w_area_sat;
    logic [AREA_W-1:0]            w_amag;
    logic signed [OUT_COORD_W-1:0] w_qx, w_qy;

    // Base point after this vertex's update
    assign w_base_x = i_vertex.set_base ? w_cx : r_base_x;
    assign w_base_y = i_vertex.set_base ? w_cy : r_base_y;

    // Twice-area of the fan triangle, sign by ring role and orientation
    always_comb begin
        w_p1 = r_dpx * r_dcy;
        w_p2 = r_dcx * r_dpy;
        if (r_flip) begin
            w_a2 = A2_W'(w_p2) - A2_W'(w_p1);
        end else begin
            w_a2 = A2_W'(w_p1) - A2_W'(w_p2);
        end
    end

    // Twice-area times three times the triangle centroid, clamped to 64 bits
    always_comb begin
        w_wpx   = r_a2 * r_c3x;
        w_wpy   = r_a2 * r_c3y;
        w_satpx = f_sat_prod(EXT_W'(w_wpx));
        w_satpy = f_sat_prod(EXT_W'(w_wpy));
    end

    // Saturating accumulation
    always_comb begin
        w_sumx     = f_sat_sum(r_wx, r_wpx);
        w_sumy     = f_sat_sum(r_wy, r_wpy);
        w_area_sum = (AREA_W+1)'(r_area) + (AREA_W+1)'(r_a2);
        w_area_ovf = (w_area_sum[AREA_W] != w_area_sum[AREA_W-1]);
        w_area_sat = w_area_ovf ? (w_area_sum[AREA_W] ? AREA_MIN : AREA_MAX)
                                : w_area_sum[AREA_W-1:0];
        w_amag     = r_area[AREA_W-1] ? (AREA_W'(0) - r_area) : r_area;
    end

    // Hold state across vertices, clear and accumulate on command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_x    <= '0;
            r_base_y    <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_wx        <= '0;
            r_wy        <= '0;
            r_area      <= '0;
            r_ovf       <= 1'b0;
            r_cnt       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_base_x <= w_base_x;
                r_base_y <= w_base_y;
                r_prev_x <= w_cx;
                r_prev_y <= w_cy;
                if (i_vertex.clear_sums) begin
                    r_wx   <= '0;
                    r_wy   <= '0;
                    r_area <= '0;
                    r_ovf  <= 1'b0;
                end
            end
            if (i_cmd.accum && r_tri) begin
                r_wx   <= w_sumx[SUM_W-1:0];
                r_wy   <= w_sumy[SUM_W-1:0];
                r_area <= w_area_sat;
                r_ovf  <= r_ovf | r_wpx_ovf | r_wpy_ovf | w_sumx[SUM_W] | w_sumy[SUM_W]
                          | w_area_ovf;
            end
            if (i_cmd.div_init) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dpx  <= DIFF_W'(r_prev_x) - DIFF_W'(w_base_x);
            r_dpy  <= DIFF_W'(r_prev_y) - DIFF_W'(w_base_y);
            r_dcx  <= DIFF_W'(w_cx) - DIFF_W'(w_base_x);
            r_dcy  <= DIFF_W'(w_cy) - DIFF_W'(w_base_y);
            r_c3x  <= C3_W'(w_base_x) + C3_W'(r_prev_x) + C3_W'(w_cx);
            r_c3y  <= C3_W'(w_base_y) + C3_W'(r_prev_y) + C3_W'(w_cy);
            r_flip <= i_vertex.is_hole ^ i_vertex.ring_ccw;
            r_tri  <= ~i_vertex.ring_start;
            r_want <= i_vertex.want_result;
        end
        if (i_cmd.area) begin
            r_a2 <= w_a2;
        end
        if (i_cmd.weight) begin
            r_wpx     <= w_satpx[SUM_W-1:0];
            r_wpy     <= w_satpy[SUM_W-1:0];
            r_wpx_ovf <= w_satpx[SUM_W];
            r_wpy_ovf <= w_satpy[SUM_W];
        end
        if (i_cmd.div_init) begin
            r_den <= DEN_W'(w_amag) + (DEN_W'(w_amag) << 1);
        end
        if (i_cmd.load_out) begin
            r_res.centroid_x       <= (r_area == '0) ? '0 : w_qx;
            r_res.centroid_y       <= (r_area == '0) ? '0 : w_qy;
            r_res.centroid_defined <= (r_area != '0);
            r_res.sum_overflow     <= r_ovf;
        end
    end

    // Divider lanes for x and y
    pac_div_lane u_div_x (
        .i_clk      (i_clk),
        .i_init     (i_cmd.div_init),
        .i_step     (i_cmd.div_step),
        .i_num      (r_wx),
        .i_area_neg (r_area[AREA_W-1]),
        .i_den      (r_den),
        .o_quot     (w_qx)
    );

    pac_div_lane u_div_y (
        .i_clk      (i_clk),
        .i_init     (i_cmd.div_init),
        .i_step     (i_cmd.div_step),
        .i_num      (r_wy),
        .i_area_neg (r_area[AREA_W-1]),
        .i_den      (r_den),
        .o_quot     (w_qy)
    );

    // Status to the controller
    always_comb begin
        o_sts.want_result = r_want;
        o_sts.area_zero   = (r_area == '0);
        o_sts.div_last    = (r_cnt == CNT_W'(DIV_STEPS - 1));
        o_sts.out_free    = ~r_res_valid | i_res_ready;
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

// ----- design/pac_ctrl.sv -----
// ----------------------------------------------------------------------------
// pac_ctrl
// Controller: sequences capture, area, weight and accumulate per vertex,
// then the divide (skipped for zero area) and the output load when a result is requested.
// ----------------------------------------------------------------------------
`include "polygon_area_centroid_macros.svh"

module pac_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pac_pkg::t_pac_sts i_sts,
    output pac_pkg::t_pac_cmd o_cmd
);
    import pac_pkg::*;

    t_pac_state r_state;
    t_pac_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_AREA;
                end
            end
            ST_AREA: begin
                o_cmd.area = 1'b1;
                n_state    = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                o_cmd.weight = 1'b1;
                n_state      = ST_ACCUM;
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_sts.want_result ? ST_DIV_INIT : ST_IDLE;
            end
            ST_DIV_INIT: begin
                if (i_sts.area_zero) begin
                    n_state = ST_LOAD;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `PAC_ASSERT_NEXT(a_accept_starts_area, i_in_valid && o_in_ready, r_state == ST_AREA, "accepted vertex did not start area step")
    `PAC_ASSERT_NEXT(a_div_ends_in_load, (r_state == ST_DIV) && i_sts.div_last, r_state == ST_LOAD, "divide did not finish into load")
    `PAC_ASSERT_NEXT(a_zero_area_skips_div, (r_state == ST_DIV_INIT) && i_sts.area_zero, r_state == ST_LOAD, "zero area did not skip the divide")
    `PAC_ASSERT_NOW(a_load_needs_free_slot, o_cmd.load_out, i_sts.out_free && (r_state == ST_LOAD), "result loaded into occupied output")

endmodule

// ----- design/polygon_area_centroid.sv -----
// Vertex without a result request: capture, area, weight and accumulate, then ready again.
// With a result: accumulate, divide init, one divide step per quotient bit, then the load
// into the output register, which waits for the output to free before returning to ready.
// Zero total area skips the divide: divide init goes straight to the load.
// Output register holds a result while the next vertex is accepted.
// Synchronous active-low reset zeroes base, previous vertex, sums and flags.
// ----------------------------------------------------------------------------
// polygon_area_centroid
// Area-weighted polygon centroid over a stream of ring vertices: fan
// triangle accumulation with saturation, centroid divide on request.
// ----------------------------------------------------------------------------
module polygon_area_centroid #(
    parameter int COORD_BITS    = pac_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = pac_pkg::FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pac_chan_if.sink   i_vertex,
    pac_chan_if.source o_result
);
    import pac_pkg::*;

    t_pac_cmd    w_cmd;
    t_pac_sts    w_sts;
    t_pac_vertex w_vertex;
    t_pac_result w_res;
    logic        w_in_ready;
    logic        w_res_valid;
    logic        w_res_ready;

    // Channel hookup
    assign w_vertex       = i_vertex.data;
    assign i_vertex.ready = w_in_ready;
    assign o_result.data  = w_res;
    assign o_result.valid = w_res_valid;
    assign w_res_ready    = o_result.ready;

    pac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vertex.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pac_dp #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_vertex    (w_vertex),
        .o_sts       (w_sts),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready)
    );

endmodule
